/* rtl/rasp_pkg.sv */
// shared types, codes and constants for the resource archive stream parser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rasp_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam int TYPE_W = 6;
   localparam int ID_W   = 16;
   localparam int LEN_W  = 23;

   typedef enum logic [2:0] {
      PH_SIG,
      PH_LEAD,
      PH_IDLO,
      PH_LEN1,
      PH_LEN2,
      PH_PAY,
      PH_DONE
   } phase_type;

   localparam logic [1:0] EV_PAYLOAD = 2'd0;
   localparam logic [1:0] EV_FINISH  = 2'd1;
   localparam logic [1:0] EV_ERROR   = 2'd2;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_SIGNATURE = 3'd1;
   localparam logic [2:0] ERR_TYPE      = 3'd2;
   localparam logic [2:0] ERR_ID        = 3'd3;
   localparam logic [2:0] ERR_TRUNCATED = 3'd4;

   localparam logic [1:0] LEAD_TYPE  = 2'b00;
   localparam logic [1:0] LEAD_ID    = 2'b01;
   localparam logic [1:0] LEAD_SHORT = 2'b10;
   localparam logic [1:0] LEAD_LONG  = 2'b11;

   localparam logic [LEN_W-1:0] LONG_BIAS = LEN_W'(65);

   // one queue entry: an optional payload event and an optional closing event
   typedef struct packed {
      logic              has_pay;
      logic [TYPE_W-1:0] type_id;
      logic [ID_W-1:0]   resource_id;
      logic [7:0]        data_byte;
      logic [LEN_W-1:0]  resource_length;
      logic [LEN_W-1:0]  byte_offset;
      logic              last_of_resource;
      logic              has_tail;
      logic [1:0]        tail_kind;
      logic [2:0]        error_code;
   } rec_type;

   function automatic logic [7:0] sig_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0: b = 8'h00;
         3'd1: b = 8'hff;
         3'd2: b = 8'h50;
         3'd3: b = 8'h42;
         3'd4: b = 8'h4c;
         3'd5: b = 8'h52;
         3'd6: b = 8'h4f;
         3'd7: b = 8'h4d;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

/* rtl/rasp_front.sv */
// front end: signature check, lead byte decode and archive state, one byte per cycle while q_full is low
// depends on rasp_pkg
`timescale 1ns / 1ps
`default_nettype none

module rasp_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [7:0]       req_rom_byte,
   input  wire logic             req_end_of_rom,
   input  wire logic             q_full,
   output logic                  req_stall,
   output logic                  q_push,
   output rasp_pkg::rec_type     q_rec
);

   rasp_pkg::phase_type phase_ff, phase_in;
   logic [2:0]                  sig_idx_ff, sig_idx_in;
   logic [rasp_pkg::TYPE_W-1:0] type_ff, type_in;
   logic [16:0]                 id_ff, id_in;
   logic [5:0]                  dhi_ff, dhi_in;
   logic [rasp_pkg::LEN_W-1:0]  acc_ff, acc_in;
   logic [rasp_pkg::LEN_W-1:0]  off_ff, off_in;

   logic        accept;
   logic [2:0]  err;
   logic        at_lead;
   logic        stop;
   logic        fin_ok;
   logic        fin;
   logic [6:0]  type_sum;
   logic [17:0] id_sum;
   logic [23:0] off_next;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign type_sum  = {1'b0, type_ff} + {1'b0, req_rom_byte[5:0]};
   assign id_sum    = {1'b0, id_ff} + {4'b0, dhi_ff, req_rom_byte};
   assign off_next  = {1'b0, off_ff} + 24'd1;
   assign fin       = off_next >= {1'b0, acc_ff};

   always_comb begin
      phase_in   = phase_ff;
      sig_idx_in = sig_idx_ff;
      type_in    = type_ff;
      id_in      = id_ff;
      dhi_in     = dhi_ff;
      acc_in     = acc_ff;
      off_in     = off_ff;
      err        = rasp_pkg::ERR_NONE;
      at_lead    = 1'b0;
      stop       = 1'b0;
      fin_ok     = 1'b0;

      q_rec                  = '0;
      q_rec.type_id          = type_ff;
      q_rec.resource_id      = id_ff[15:0];
      q_rec.data_byte        = req_rom_byte;
      q_rec.resource_length  = acc_ff;
      q_rec.byte_offset      = off_ff;
      q_rec.last_of_resource = fin;

      case (phase_ff)
         rasp_pkg::PH_SIG: begin
            if (req_rom_byte != rasp_pkg::sig_byte(sig_idx_ff)) begin
               err = rasp_pkg::ERR_SIGNATURE;
            end else if (sig_idx_ff == 3'd7) begin
               phase_in = rasp_pkg::PH_LEAD;
               at_lead  = 1'b1;
            end else begin
               sig_idx_in = sig_idx_ff + 3'd1;
               if (req_end_of_rom) err = rasp_pkg::ERR_SIGNATURE;
            end
         end
         rasp_pkg::PH_LEAD: begin
            if (req_rom_byte == 8'h00) begin
               fin_ok = 1'b1;
               stop   = 1'b1;
            end else begin
               case (req_rom_byte[7:6])
                  rasp_pkg::LEAD_TYPE: begin
                     if (type_sum[6]) begin
                        err = rasp_pkg::ERR_TYPE;
                     end else begin
                        type_in = type_sum[5:0];
                        id_in   = 17'd1;
                        at_lead = 1'b1;
                     end
                  end
                  rasp_pkg::LEAD_ID: begin
                     dhi_in   = req_rom_byte[5:0];
                     phase_in = rasp_pkg::PH_IDLO;
                     if (req_end_of_rom) err = rasp_pkg::ERR_TRUNCATED;
                  end
                  rasp_pkg::LEAD_SHORT: begin
                     if (id_ff[16]) begin
                        err = rasp_pkg::ERR_ID;
                     end else begin
                        acc_in   = rasp_pkg::LEN_W'(req_rom_byte[5:0]) + 23'd1;
                        off_in   = '0;
                        phase_in = rasp_pkg::PH_PAY;
                        if (req_end_of_rom) err = rasp_pkg::ERR_TRUNCATED;
                     end
                  end
                  rasp_pkg::LEAD_LONG: begin
                     acc_in   = rasp_pkg::LEN_W'(req_rom_byte[5:0]);
                     phase_in = rasp_pkg::PH_LEN1;
                     if (req_end_of_rom) err = rasp_pkg::ERR_TRUNCATED;
                  end
                  default: begin
                  end
               endcase
            end
         end
         rasp_pkg::PH_IDLO: begin
            if (id_sum[17:16] != 2'b00) begin
               err = rasp_pkg::ERR_ID;
            end else begin
               id_in    = id_sum[16:0];
               phase_in = rasp_pkg::PH_LEAD;
               at_lead  = 1'b1;
            end
         end
         rasp_pkg::PH_LEN1: begin
            acc_in   = rasp_pkg::LEN_W'({acc_ff[5:0], req_rom_byte});
            phase_in = rasp_pkg::PH_LEN2;
            if (req_end_of_rom) err = rasp_pkg::ERR_TRUNCATED;
         end
         rasp_pkg::PH_LEN2: begin
            acc_in = rasp_pkg::LEN_W'({acc_ff[13:0], req_rom_byte}) + rasp_pkg::LONG_BIAS;
            if (id_ff[16]) begin
               err = rasp_pkg::ERR_ID;
            end else begin
               off_in   = '0;
               phase_in = rasp_pkg::PH_PAY;
               if (req_end_of_rom) err = rasp_pkg::ERR_TRUNCATED;
            end
         end
         rasp_pkg::PH_PAY: begin
            q_rec.has_pay = 1'b1;
            if (fin) begin
               id_in    = id_ff + 17'd1;
               off_in   = '0;
               phase_in = rasp_pkg::PH_LEAD;
               at_lead  = 1'b1;
            end else begin
               off_in = off_next[rasp_pkg::LEN_W-1:0];
               if (req_end_of_rom) err = rasp_pkg::ERR_TRUNCATED;
            end
         end
         default: begin
         end
      endcase

      if (err != rasp_pkg::ERR_NONE) begin
         q_rec.has_tail   = 1'b1;
         q_rec.tail_kind  = rasp_pkg::EV_ERROR;
         q_rec.error_code = err;
         stop             = 1'b1;
      end else if (fin_ok || (at_lead && req_end_of_rom)) begin
         q_rec.has_tail  = 1'b1;
         q_rec.tail_kind = rasp_pkg::EV_FINISH;
      end

      if (stop) phase_in = rasp_pkg::PH_DONE;

      // end of archive: back to the reset state for the next one
      if (req_end_of_rom) begin
         phase_in   = rasp_pkg::PH_SIG;
         sig_idx_in = '0;
         type_in    = rasp_pkg::TYPE_W'(1);
         id_in      = 17'd1;
         dhi_in     = '0;
         acc_in     = '0;
         off_in     = '0;
      end

      q_push = accept && (q_rec.has_pay || q_rec.has_tail);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= rasp_pkg::PH_SIG;
         sig_idx_ff <= '0;
         type_ff    <= rasp_pkg::TYPE_W'(1);
         id_ff      <= 17'd1;
         dhi_ff     <= '0;
         acc_ff     <= '0;
         off_ff     <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         sig_idx_ff <= sig_idx_in;
         type_ff    <= type_in;
         id_ff      <= id_in;
         dhi_ff     <= dhi_in;
         acc_ff     <= acc_in;
         off_ff     <= off_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/rasp_queue.sv */
// small first-in first-out queue of decoded records between front and back end
// depends on rasp_pkg
`timescale 1ns / 1ps
`default_nettype none

module rasp_queue #(
   parameter int Depth = rasp_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire rasp_pkg::rec_type push_rec,
   output logic                   full,
   input  wire logic              pop,
   output rasp_pkg::rec_type      head_rec,
   output logic                   not_empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   rasp_pkg::rec_type mem [Depth];

   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full      = count_ff == CntW'(Depth);
   assign not_empty = count_ff != '0;
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_rec  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/rasp_back.sv */
// back end: output register that plays out each record as one or two result transactions
// depends on rasp_pkg
`timescale 1ns / 1ps
`default_nettype none

module rasp_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire rasp_pkg::rec_type           head_rec,
   input  wire logic                        not_empty,
   output logic                             pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [1:0]                       rsp_event_kind,
   output logic [rasp_pkg::TYPE_W-1:0]      rsp_type_id,
   output logic [rasp_pkg::ID_W-1:0]        rsp_resource_id,
   output logic [7:0]                       rsp_data_byte,
   output logic [rasp_pkg::LEN_W-1:0]       rsp_resource_length,
   output logic [rasp_pkg::LEN_W-1:0]       rsp_byte_offset,
   output logic                             rsp_last_of_resource,
   output logic [2:0]                       rsp_error_code,
   output logic                             rsp_last
);

   rasp_pkg::rec_type rec_ff;
   logic              valid_ff;
   logic              pay_done_ff;
   logic              show_pay;
   logic              final_one;
   logic              taken;

   assign show_pay  = rec_ff.has_pay && !pay_done_ff;
   assign final_one = !show_pay || !rec_ff.has_tail;
   assign taken     = valid_ff && !rsp_stall;
   assign pop       = not_empty && (!valid_ff || (taken && final_one));

   assign rsp_valid            = valid_ff;
   assign rsp_event_kind       = show_pay ? rasp_pkg::EV_PAYLOAD : rec_ff.tail_kind;
   assign rsp_type_id          = show_pay ? rec_ff.type_id : '0;
   assign rsp_resource_id      = show_pay ? rec_ff.resource_id : '0;
   assign rsp_data_byte        = show_pay ? rec_ff.data_byte : '0;
   assign rsp_resource_length  = show_pay ? rec_ff.resource_length : '0;
   assign rsp_byte_offset      = show_pay ? rec_ff.byte_offset : '0;
   assign rsp_last_of_resource = show_pay ? rec_ff.last_of_resource : 1'b0;
   assign rsp_error_code       = show_pay ? rasp_pkg::ERR_NONE : rec_ff.error_code;
   assign rsp_last             = final_one;

   always_ff @(posedge clock) begin
      if (pop) begin
         rec_ff <= head_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         pay_done_ff <= 1'b0;
      end else if (pop) begin
         valid_ff    <= 1'b1;
         pay_done_ff <= 1'b0;
      end else if (taken) begin
         if (final_one) begin
            valid_ff <= 1'b0;
         end else begin
            pay_done_ff <= 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/resource_archive_stream_parser.sv */
// top level of the resource archive stream parser: front end, record queue, back end
// depends on rasp_pkg, rasp_front, rasp_queue, rasp_back
`timescale 1ns / 1ps
`default_nettype none

// Takes one archive byte per cycle on the req_ channel while req_stall is low and gives
// payload, finished and error transactions on the rsp_ channel. The front end decodes
// each byte in the cycle it is accepted and writes at most one record into a
// QueueDepth-entry queue; the back end plays each record out as one or two transactions,
// so a byte that yields both a payload byte and a closing event needs two transactions.
// Sustained rate is one byte per cycle while rsp_stall stays low and the queue has room;
// the queue absorbs the extra transaction of such bytes, and req_stall rises only when
// the queue is full. Each record is written into the queue, then into the output register.
module resource_archive_stream_parser #(
   parameter int QueueDepth = rasp_pkg::QUEUE_DEPTH
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [7:0]                  req_rom_byte,
   input  wire logic                        req_end_of_rom,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [1:0]                       rsp_event_kind,
   output logic [rasp_pkg::TYPE_W-1:0]      rsp_type_id,
   output logic [rasp_pkg::ID_W-1:0]        rsp_resource_id,
   output logic [7:0]                       rsp_data_byte,
   output logic [rasp_pkg::LEN_W-1:0]       rsp_resource_length,
   output logic [rasp_pkg::LEN_W-1:0]       rsp_byte_offset,
   output logic                             rsp_last_of_resource,
   output logic [2:0]                       rsp_error_code,
   output logic                             rsp_last
);

   rasp_pkg::rec_type push_rec;
   rasp_pkg::rec_type head_rec;
   logic              push;
   logic              full;
   logic              pop;
   logic              not_empty;

   rasp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_rom_byte   (req_rom_byte),
      .req_end_of_rom (req_end_of_rom),
      .q_full         (full),
      .req_stall      (req_stall),
      .q_push         (push),
      .q_rec          (push_rec)
   );

   rasp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rec  (push_rec),
      .full      (full),
      .pop       (pop),
      .head_rec  (head_rec),
      .not_empty (not_empty)
   );

   rasp_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head_rec             (head_rec),
      .not_empty            (not_empty),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_event_kind       (rsp_event_kind),
      .rsp_type_id          (rsp_type_id),
      .rsp_resource_id      (rsp_resource_id),
      .rsp_data_byte        (rsp_data_byte),
      .rsp_resource_length  (rsp_resource_length),
      .rsp_byte_offset      (rsp_byte_offset),
      .rsp_last_of_resource (rsp_last_of_resource),
      .rsp_error_code       (rsp_error_code),
      .rsp_last             (rsp_last)
   );

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// self-checking testbench for resource_archive_stream_parser: directed and random archives
// depends on rasp_pkg and the resource_archive_stream_parser rtl
`timescale 1ns / 1ps

module tb_top;

   localparam int TARGET_BYTES   = 1400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 16;
   localparam logic [63:0] ARCHIVE_MAGIC = 64'h00ff_5042_4c52_4f4d;

   typedef struct packed {
      logic [7:0] rom_byte;
      logic       eor;
   } rom_item_type;

   typedef struct packed {
      logic [1:0]                  kind;
      logic [rasp_pkg::TYPE_W-1:0] type_id;
      logic [rasp_pkg::ID_W-1:0]   res_id;
      logic [7:0]                  data;
      logic [rasp_pkg::LEN_W-1:0]  length;
      logic [rasp_pkg::LEN_W-1:0]  offset;
      logic                        lor;
      logic [2:0]                  err;
      logic                        last;
   } archive_event_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [7:0]       req_rom_byte = 8'd0;
   logic             req_end_of_rom = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [1:0]       rsp_event_kind;
   logic [rasp_pkg::TYPE_W-1:0] rsp_type_id;
   logic [rasp_pkg::ID_W-1:0]  rsp_resource_id;
   logic [7:0]       rsp_data_byte;
   logic [rasp_pkg::LEN_W-1:0] rsp_resource_length;
   logic [rasp_pkg::LEN_W-1:0] rsp_byte_offset;
   logic             rsp_last_of_resource;
   logic [2:0]       rsp_error_code;
   logic             rsp_last;

   rom_item_type      pending[$];
   logic [7:0]        arc_buf[$];
   archive_event_type due_events[$];
   archive_event_type due_event;
   rom_item_type      next_item;

   // parser state
   rasp_pkg::phase_type         parse_state;
   logic [2:0]                  sig_idx;
   logic [rasp_pkg::TYPE_W-1:0] cur_type;
   logic [16:0]                 cur_id;
   logic [5:0]                  id_hi;
   logic [rasp_pkg::LEN_W-1:0]  len_acc;
   logic [rasp_pkg::LEN_W-1:0]  pay_off;

   int  total_items;
   int  sent_count;
   int  idle_phase;
   int  mismatch_count;
   int  result_count;
   int  quiet_cycles;
   logic req_fire = 1'b0;

   resource_archive_stream_parser DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rom_byte        (req_rom_byte),
      .req_end_of_rom      (req_end_of_rom),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_event_kind      (rsp_event_kind),
      .rsp_type_id         (rsp_type_id),
      .rsp_resource_id     (rsp_resource_id),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_resource_length (rsp_resource_length),
      .rsp_byte_offset     (rsp_byte_offset),
      .rsp_last_of_resource(rsp_last_of_resource),
      .rsp_error_code      (rsp_error_code),
      .rsp_last            (rsp_last)
   );

   always #6 clock = ~clock;

   function automatic logic [7:0] magic_byte(input int idx);
      return ARCHIVE_MAGIC[63 - 8 * idx -: 8];
   endfunction

   task automatic flag_error(input string msg);
      $display("mismatch at result %0d: %s", result_count, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want) begin
         flag_error($sformatf("%s got %0d expected %0d", name, got, want));
      end
   endtask

   // ---------------------------------------------------------------- predictor

   task automatic clear_parser();
      parse_state = rasp_pkg::PH_SIG;
      sig_idx     = 3'd0;
      cur_type    = rasp_pkg::TYPE_W'(1);
      cur_id      = 17'd1;
      id_hi       = 6'd0;
      len_acc     = '0;
      pay_off     = '0;
   endtask

   function automatic archive_event_type make_event(input logic [1:0] kind,
                                                    input logic [7:0] data,
                                                    input logic lor, input logic [2:0] err);
      archive_event_type ev;
      ev = '0;
      ev.kind = kind;
      ev.err  = err;
      if (kind == rasp_pkg::EV_PAYLOAD) begin
         ev.type_id = cur_type;
         ev.res_id  = cur_id[15:0];
         ev.data    = data;
         ev.length  = len_acc;
         ev.offset  = pay_off;
         ev.lor     = lor;
      end
      return ev;
   endfunction

   task automatic parse_byte(input logic [7:0] b, input logic eor);
      archive_event_type ev[2];
      int           n;
      logic         at_lead;
      logic         stop;
      logic         fin;
      logic [2:0]   err;
      int unsigned  sum;
      n = 0;
      at_lead = 1'b0;
      stop = 1'b0;
      err = rasp_pkg::ERR_NONE;
      case (parse_state)
         rasp_pkg::PH_SIG: begin
            if (b != magic_byte(int'(sig_idx))) begin
               err = rasp_pkg::ERR_SIGNATURE;
            end else if (sig_idx == 3'd7) begin
               parse_state = rasp_pkg::PH_LEAD;
               at_lead = 1'b1;
            end else begin
               sig_idx++;
               if (eor) err = rasp_pkg::ERR_SIGNATURE;
            end
         end
         rasp_pkg::PH_LEAD: begin
            if (b == 8'd0) begin
               ev[n] = make_event(rasp_pkg::EV_FINISH, 8'd0, 1'b0, rasp_pkg::ERR_NONE);
               n++;
               stop = 1'b1;
            end else begin
               case (b[7:6])
                  rasp_pkg::LEAD_TYPE: begin
                     sum = 32'(cur_type) + 32'(b);
                     if (sum > 63) begin
                        err = rasp_pkg::ERR_TYPE;
                     end else begin
                        cur_type = sum[rasp_pkg::TYPE_W-1:0];
                        cur_id = 17'd1;
                        at_lead = 1'b1;
                     end
                  end
                  rasp_pkg::LEAD_ID: begin
                     id_hi = b[5:0];
                     parse_state = rasp_pkg::PH_IDLO;
                     if (eor) err = rasp_pkg::ERR_TRUNCATED;
                  end
                  rasp_pkg::LEAD_SHORT: begin
                     if (cur_id > 17'hffff) begin
                        err = rasp_pkg::ERR_ID;
                     end else begin
                        len_acc = rasp_pkg::LEN_W'(b[5:0]) + rasp_pkg::LEN_W'(1);
                        pay_off = '0;
                        parse_state = rasp_pkg::PH_PAY;
                        if (eor) err = rasp_pkg::ERR_TRUNCATED;
                     end
                  end
                  default: begin
                     len_acc = rasp_pkg::LEN_W'(b[5:0]);
                     parse_state = rasp_pkg::PH_LEN1;
                     if (eor) err = rasp_pkg::ERR_TRUNCATED;
                  end
               endcase
            end
         end
         rasp_pkg::PH_IDLO: begin
            sum = 32'(cur_id) + 32'({id_hi, b});
            if (sum > 32'hffff) begin
               err = rasp_pkg::ERR_ID;
            end else begin
               cur_id = sum[16:0];
               parse_state = rasp_pkg::PH_LEAD;
               at_lead = 1'b1;
            end
         end
         rasp_pkg::PH_LEN1: begin
            len_acc = rasp_pkg::LEN_W'({len_acc[5:0], b});
            parse_state = rasp_pkg::PH_LEN2;
            if (eor) err = rasp_pkg::ERR_TRUNCATED;
         end
         rasp_pkg::PH_LEN2: begin
            len_acc = rasp_pkg::LEN_W'({len_acc[13:0], b}) + rasp_pkg::LONG_BIAS;
            if (cur_id > 17'hffff) begin
               err = rasp_pkg::ERR_ID;
            end else begin
               pay_off = '0;
               parse_state = rasp_pkg::PH_PAY;
               if (eor) err = rasp_pkg::ERR_TRUNCATED;
            end
         end
         rasp_pkg::PH_PAY: begin
            fin = ({1'b0, pay_off} + 24'd1) >= {1'b0, len_acc};
            ev[n] = make_event(rasp_pkg::EV_PAYLOAD, b, fin, rasp_pkg::ERR_NONE);
            n++;
            if (fin) begin
               cur_id = cur_id + 17'd1;
               pay_off = '0;
               parse_state = rasp_pkg::PH_LEAD;
               at_lead = 1'b1;
            end else begin
               pay_off = pay_off + rasp_pkg::LEN_W'(1);
               if (eor) err = rasp_pkg::ERR_TRUNCATED;
            end
         end
         default: ;
      endcase
      if (err != rasp_pkg::ERR_NONE) begin
         ev[n] = make_event(rasp_pkg::EV_ERROR, 8'd0, 1'b0, err);
         n++;
         stop = 1'b1;
      end else if (at_lead && eor) begin
         ev[n] = make_event(rasp_pkg::EV_FINISH, 8'd0, 1'b0, rasp_pkg::ERR_NONE);
         n++;
      end
      if (stop) parse_state = rasp_pkg::PH_DONE;
      if (eor) clear_parser();
      for (int i = 0; i < n; i++) begin
         ev[i].last = (i == n - 1);
         due_events.push_back(ev[i]);
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   task automatic put_magic(input int count);
      for (int i = 0; i < count; i++) arc_buf.push_back(magic_byte(i));
   endtask

   task automatic close_archive();
      rom_item_type it;
      for (int i = 0; i < arc_buf.size(); i++) begin
         it.rom_byte = arc_buf[i];
         it.eor = (i == arc_buf.size() - 1);
         pending.push_back(it);
      end
      arc_buf.delete();
   endtask

   task automatic put_payload(input int count);
      repeat (count) arc_buf.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic build_archive();
      int pick;
      int kind;
      int k;
      int len;
      int keep;
      int ending;
      logic cut_short;
      pick = $urandom_range(0, 99);
      cut_short = 1'b0;
      if (pick < 6) begin
         // noise
         put_payload($urandom_range(1, 10));
      end else if (pick < 14) begin
         // broken signature
         k = $urandom_range(0, 7);
         put_magic(k);
         if (k == 0 || $urandom_range(0, 1) == 1) begin
            arc_buf.push_back(magic_byte(k) ^ 8'($urandom_range(1, 255)));
            put_payload($urandom_range(0, 3));
         end
      end else begin
         put_magic(8);
         if (pick < 26) begin
            // climb the resource id up to the 16-bit limit
            repeat (4) begin
               arc_buf.push_back(8'h7f);
               arc_buf.push_back(8'hff);
            end
            arc_buf.push_back(8'h40);
            arc_buf.push_back(8'($urandom_range(0, 3)));
         end
         repeat ($urandom_range(1, 8)) begin
            if (!cut_short) begin
               kind = $urandom_range(0, 99);
               if (kind < 14) begin
                  if ($urandom_range(0, 3) == 0) arc_buf.push_back(8'($urandom_range(1, 63)));
                  else arc_buf.push_back(8'($urandom_range(1, 6)));
               end else if (kind < 28) begin
                  arc_buf.push_back({2'b01, 6'($urandom_range(0, 63))});
                  arc_buf.push_back(8'($urandom_range(0, 255)));
               end else if (kind < 84) begin
                  if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 64);
                  else if ($urandom_range(0, 19) == 0) len = 64;
                  else len = $urandom_range(1, 8);
                  arc_buf.push_back({2'b10, 6'(len - 1)});
                  put_payload(len);
               end else if (kind < 96) begin
                  len = $urandom_range(0, 12);
                  arc_buf.push_back(8'hc0);
                  arc_buf.push_back(8'h00);
                  arc_buf.push_back(8'(len));
                  put_payload(65 + len);
               end else begin
                  // huge resource that the archive cuts off
                  if ($urandom_range(0, 1) == 1) begin
                     arc_buf.push_back(8'hff);
                     arc_buf.push_back(8'hff);
                     arc_buf.push_back(8'hff);
                  end else begin
                     arc_buf.push_back({2'b11, 6'($urandom_range(0, 63))});
                     put_payload(2);
                  end
                  put_payload($urandom_range(0, 4));
                  cut_short = 1'b1;
               end
            end
         end
         if (!cut_short) begin
            ending = $urandom_range(0, 99);
            if (ending < 45) begin
               arc_buf.push_back(8'h00);
               put_payload($urandom_range(0, 2));
            end else if (ending >= 72) begin
               keep = $urandom_range(1, arc_buf.size());
               while (arc_buf.size() > keep) void'(arc_buf.pop_back());
            end
         end
      end
      close_archive();
   endtask

   // ---------------------------------------------------------------- driver and monitors

   always @(negedge clock) begin
      idle_phase = (total_items == 0) ? 0 : (sent_count * 4) / total_items;
      if (!reset && (!req_valid || req_fire)) begin
         if (pending.size() != 0 &&
             $urandom_range(0, 99) >= ((idle_phase == 1) ? 46 : (idle_phase == 3) ? 16 : 0))
         begin
            next_item = pending.pop_front();
            req_valid <= 1'b1;
            req_rom_byte <= next_item.rom_byte;
            req_end_of_rom <= next_item.eor;
            sent_count++;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(0, 99) <
                    ((idle_phase == 2) ? 46 : (idle_phase == 3) ? 16 : 0));
   end

   // input side: every accepted transaction goes through the parser model
   always @(posedge clock) begin
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         parse_byte(req_rom_byte, req_end_of_rom);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_events.size() == 0) begin
            flag_error($sformatf("unexpected transaction kind %0d", rsp_event_kind));
         end else begin
            due_event = due_events.pop_front();
            check_field("event_kind", 32'(rsp_event_kind), 32'(due_event.kind));
            check_field("type_id", 32'(rsp_type_id), 32'(due_event.type_id));
            check_field("resource_id", 32'(rsp_resource_id), 32'(due_event.res_id));
            check_field("data_byte", 32'(rsp_data_byte), 32'(due_event.data));
            check_field("resource_length", 32'(rsp_resource_length),
                        32'(due_event.length));
            check_field("byte_offset", 32'(rsp_byte_offset), 32'(due_event.offset));
            check_field("last_of_resource", 32'(rsp_last_of_resource),
                        32'(due_event.lor));
            check_field("error_code", 32'(rsp_error_code), 32'(due_event.err));
            check_field("last", 32'(rsp_last), 32'(due_event.last));
         end
         result_count++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      total_items = 0;
      sent_count = 0;
      idle_phase = 0;
      mismatch_count = 0;
      result_count = 0;
      quiet_cycles = 0;
      clear_parser();

      // two-byte payload of 0x00 and 0xff, largest id step, type up to 63 then past it
      put_magic(8);
      arc_buf.push_back(8'h81);
      arc_buf.push_back(8'h00);
      arc_buf.push_back(8'hff);
      arc_buf.push_back(8'h7f);
      arc_buf.push_back(8'hff);
      arc_buf.push_back(8'h3e);
      arc_buf.push_back(8'h01);
      arc_buf.push_back(8'haa);
      close_archive();
      // bad signature, then ignored bytes
      arc_buf.push_back(8'h00);
      arc_buf.push_back(8'hfe);
      arc_buf.push_back(8'h12);
      close_archive();
      // archive shorter than the signature
      put_magic(3);
      close_archive();

      while (pending.size() < TARGET_BYTES) build_archive();
      total_items = pending.size();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || req_valid) @(posedge clock);
      while (due_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && due_events.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
